/* hdl/bvcs_pkg.sv */
package bvcs_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_LIN_DZ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANG_DZ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANAR_LIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIM = 3'd4;

	// register reset values
	localparam logic [9:0] LIN_DZ_RST = 10'd5;
	localparam logic [9:0] ANG_DZ_RST = 10'd20;
	localparam logic [9:0] GAIN_RST = 10'd100;
	localparam logic [15:0] PLANAR_LIM_RST = 16'd51200;
	localparam logic [15:0] TURN_LIM_RST = 16'd20480;

	// datapath widths
	localparam int MAG_W = 28;             // planar magnitude after gain
	localparam int SQ_W = 2 * MAG_W + 2;   // radicand, even width
	localparam int RT_W = SQ_W / 2;        // square root
	localparam int NUM_W = MAG_W + 16;     // magnitude times limit
	localparam int QT_W = 17;              // scaled quotient
	localparam int CMD_W = 17;

	// sideband that follows an item through the root and divide pipelines
	typedef struct packed {
		logic pose;
		logic over;
		logic f_neg;
		logic l_neg;
		logic [MAG_W-1:0] f_mag;
		logic [MAG_W-1:0] l_mag;
		logic [CMD_W-1:0] turn;
	} side_t;

endpackage

/* hdl/bvcs_isqrt.sv */
module bvcs_isqrt import bvcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [SQ_W-1:0] in_rad,
	input side_t in_side,
	output logic out_valid,
	output logic [RT_W-1:0] out_root,
	output side_t out_side
);

	localparam int REM_W = RT_W + 3;

	logic [RT_W:1] v_s;
	logic [SQ_W-1:0] rad_s [1:RT_W];
	logic [REM_W-1:0] rem_s [1:RT_W];
	logic [RT_W-1:0] root_s [1:RT_W];
	side_t side_s [1:RT_W];

	// one root bit per stage, two radicand bits brought down each time
	for (genvar k = 0; k < RT_W; k++) begin : g_step
		logic v_in;
		logic [SQ_W-1:0] rad_in;
		logic [REM_W-1:0] rem_in;
		logic [RT_W-1:0] root_in;
		side_t side_in;
		logic [REM_W-1:0] nxt;
		logic [REM_W-1:0] trial;
		logic ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign rad_in = in_rad;
			assign rem_in = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_rest
			assign v_in = v_s[k];
			assign rad_in = rad_s[k];
			assign rem_in = rem_s[k];
			assign root_in = root_s[k];
			assign side_in = side_s[k];
		end

		assign nxt = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge = (nxt >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_in << 2;
				rem_s[k+1] <= ge ? (nxt - trial) : nxt;
				root_s[k+1] <= {root_in[RT_W-2:0], ge};
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = v_s[RT_W];
	assign out_root = root_s[RT_W];
	assign out_side = side_s[RT_W];

endmodule

/* hdl/bvcs_div.sv */
module bvcs_div import bvcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [NUM_W-1:0] in_num_f,
	input logic [NUM_W-1:0] in_num_l,
	input logic [RT_W-1:0] in_den,
	input side_t in_side,
	output logic out_valid,
	output logic [QT_W-1:0] out_q_f,
	output logic [QT_W-1:0] out_q_l,
	output side_t out_side
);

	localparam int CMP_W = RT_W + QT_W;

	logic [QT_W:1] v_s;
	logic [NUM_W-1:0] nf_s [1:QT_W];
	logic [NUM_W-1:0] nl_s [1:QT_W];
	logic [RT_W-1:0] den_s [1:QT_W];
	logic [QT_W-1:0] qf_s [1:QT_W];
	logic [QT_W-1:0] ql_s [1:QT_W];
	side_t side_s [1:QT_W];

	// restoring division, one quotient bit per stage, both components side by side
	for (genvar k = 0; k < QT_W; k++) begin : g_step
		localparam int SH = QT_W - 1 - k;
		logic v_in;
		logic [NUM_W-1:0] nf_in;
		logic [NUM_W-1:0] nl_in;
		logic [RT_W-1:0] den_in;
		logic [QT_W-1:0] qf_in;
		logic [QT_W-1:0] ql_in;
		side_t side_in;
		logic [CMP_W-1:0] dsh;
		logic ge_f;
		logic ge_l;
		logic [CMP_W-1:0] df;
		logic [CMP_W-1:0] dl;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign nf_in = in_num_f;
			assign nl_in = in_num_l;
			assign den_in = in_den;
			assign qf_in = '0;
			assign ql_in = '0;
			assign side_in = in_side;
		end else begin : g_rest
			assign v_in = v_s[k];
			assign nf_in = nf_s[k];
			assign nl_in = nl_s[k];
			assign den_in = den_s[k];
			assign qf_in = qf_s[k];
			assign ql_in = ql_s[k];
			assign side_in = side_s[k];
		end

		assign dsh = CMP_W'(den_in) << SH;
		assign ge_f = (CMP_W'(nf_in) >= dsh);
		assign ge_l = (CMP_W'(nl_in) >= dsh);
		assign df = CMP_W'(nf_in) - dsh;
		assign dl = CMP_W'(nl_in) - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nf_s[k+1] <= ge_f ? df[NUM_W-1:0] : nf_in;
				nl_s[k+1] <= ge_l ? dl[NUM_W-1:0] : nl_in;
				den_s[k+1] <= den_in;
				qf_s[k+1] <= {qf_in[QT_W-2:0], ge_f};
				ql_s[k+1] <= {ql_in[QT_W-2:0], ge_l};
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = v_s[QT_W];
	assign out_q_f = qf_s[QT_W];
	assign out_q_l = ql_s[QT_W];
	assign out_side = side_s[QT_W];

endmodule

/* hdl/body_velocity_command_shaper_unit.sv */
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   rotation columns, world velocity, gyro y, flags
// out       output     out_valid / out_ready forward_cmd, left_cmd, turn_cmd, cmd_valid
// cfg       input      cfg_wr_en             cfg_addr, cfg_wdata
//
// one item enters per cycle while the pipeline is not held; stages: 5 front stages, 29 square root
// stages (one root bit each), one product stage, 17 divide stages, one output stage.
// reset clears all valid bits and loads the register defaults.
// the whole pipeline holds while the output register has a result and out_ready is low;
// in_ready follows that hold, so nothing is dropped or repeated.
module body_velocity_command_shaper_unit import bvcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_addr,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic signed [15:0] rot_col0_x,
	input logic signed [15:0] rot_col0_y,
	input logic signed [15:0] rot_col0_z,
	input logic signed [15:0] rot_col2_x,
	input logic signed [15:0] rot_col2_y,
	input logic signed [15:0] rot_col2_z,
	input logic signed [15:0] world_vel_x,
	input logic signed [15:0] world_vel_y,
	input logic signed [15:0] world_vel_z,
	input logic signed [15:0] gyro_rate_y,
	input logic imu_valid,
	input logic pose_valid,
	output logic out_valid,
	input logic out_ready,
	output logic signed [CMD_W-1:0] forward_cmd,
	output logic signed [CMD_W-1:0] left_cmd,
	output logic signed [CMD_W-1:0] turn_cmd,
	output logic cmd_valid
);

	logic en;

	logic [9:0] lin_dz_q;
	logic [9:0] ang_dz_q;
	logic [9:0] gain_q;
	logic [15:0] plim_q;
	logic [15:0] tlim_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_dz_q <= LIN_DZ_RST;
			ang_dz_q <= ANG_DZ_RST;
			gain_q <= GAIN_RST;
			plim_q <= PLANAR_LIM_RST;
			tlim_q <= TURN_LIM_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_LIN_DZ: lin_dz_q <= cfg_wdata[9:0];
				CFG_ANG_DZ: ang_dz_q <= cfg_wdata[9:0];
				CFG_GAIN: gain_q <= cfg_wdata[9:0];
				CFG_PLANAR_LIM: plim_q <= cfg_wdata;
				CFG_TURN_LIM: tlim_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// global advance: the output register is free or being drained
	logic v_s7;
	assign en = !v_s7 || out_ready;
	assign in_ready = en;

	// stage 1: rotation products, turn source
	logic v_s1;
	logic signed [31:0] p_s1 [0:5];
	logic signed [CMD_W-1:0] turn_s1;
	logic pose_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= 32'(rot_col0_x) * 32'(world_vel_x);
			p_s1[1] <= 32'(rot_col0_y) * 32'(world_vel_y);
			p_s1[2] <= 32'(rot_col0_z) * 32'(world_vel_z);
			p_s1[3] <= 32'(rot_col2_x) * 32'(world_vel_x);
			p_s1[4] <= 32'(rot_col2_y) * 32'(world_vel_y);
			p_s1[5] <= 32'(rot_col2_z) * 32'(world_vel_z);
			turn_s1 <= imu_valid ? -CMD_W'(gyro_rate_y) : '0;
			pose_s1 <= pose_valid;
		end
	end

	// stage 2: rounded dot products, turn deadzone
	logic v_s2;
	logic signed [19:0] fwd_s2;
	logic signed [19:0] left_s2;
	logic [CMD_W-1:0] tmag_s2;
	logic tneg_s2;
	logic pose_s2;
	logic signed [33:0] sum_z;
	logic signed [33:0] sum_x;
	logic [CMD_W-1:0] tmag1;

	always_comb begin
		sum_z = 34'(p_s1[3]) + 34'(p_s1[4]) + 34'(p_s1[5]) + 34'sd8192;
		sum_x = 34'(p_s1[0]) + 34'(p_s1[1]) + 34'(p_s1[2]) + 34'sd8192;
		tmag1 = turn_s1[CMD_W-1] ? CMD_W'(-turn_s1) : CMD_W'(turn_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s2 <= sum_z[33:14];
			left_s2 <= -sum_x[33:14];
			tmag_s2 <= (tmag1 < CMD_W'(ang_dz_q)) ? '0 : tmag1;
			tneg_s2 <= turn_s1[CMD_W-1];
			pose_s2 <= pose_s1;
		end
	end

	// stage 3: linear deadzones and gain
	logic v_s3;
	logic [MAG_W-1:0] fmag_s3;
	logic [MAG_W-1:0] lmag_s3;
	logic fneg_s3;
	logic lneg_s3;
	logic [26:0] tmag_s3;
	logic tneg_s3;
	logic pose_s3;
	logic [19:0] fabs;
	logic [19:0] labs;
	logic [19:0] fdz;
	logic [19:0] ldz;
	logic [29:0] fprod;
	logic [29:0] lprod;

	always_comb begin
		fabs = fwd_s2[19] ? 20'(-fwd_s2) : 20'(fwd_s2);
		labs = left_s2[19] ? 20'(-left_s2) : 20'(left_s2);
		fdz = (fabs < 20'(lin_dz_q)) ? '0 : fabs;
		ldz = (labs < 20'(lin_dz_q)) ? '0 : labs;
		fprod = 30'(fdz) * 30'(gain_q);
		lprod = 30'(ldz) * 30'(gain_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmag_s3 <= fprod[MAG_W-1:0];
			lmag_s3 <= lprod[MAG_W-1:0];
			fneg_s3 <= fwd_s2[19];
			lneg_s3 <= left_s2[19];
			tmag_s3 <= 27'(tmag_s2) * 27'(gain_q);
			tneg_s3 <= tneg_s2;
			pose_s3 <= pose_s2;
		end
	end

	// stage 4: squares, limit square, turn clamp
	logic v_s4;
	logic [2*MAG_W-1:0] fsq_s4;
	logic [2*MAG_W-1:0] lsq_s4;
	logic [31:0] limsq_s4;
	logic [MAG_W-1:0] fmag_s4;
	logic [MAG_W-1:0] lmag_s4;
	logic fneg_s4;
	logic lneg_s4;
	logic [CMD_W-1:0] turn_s4;
	logic pose_s4;
	logic [15:0] tclamp;

	assign tclamp = (tmag_s3 > 27'(tlim_q)) ? tlim_q : tmag_s3[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fsq_s4 <= (2*MAG_W)'(fmag_s3) * (2*MAG_W)'(fmag_s3);
			lsq_s4 <= (2*MAG_W)'(lmag_s3) * (2*MAG_W)'(lmag_s3);
			limsq_s4 <= 32'(plim_q) * 32'(plim_q);
			fmag_s4 <= fmag_s3;
			lmag_s4 <= lmag_s3;
			fneg_s4 <= fneg_s3;
			lneg_s4 <= lneg_s3;
			turn_s4 <= tneg_s3 ? -CMD_W'(tclamp) : CMD_W'(tclamp);
			pose_s4 <= pose_s3;
		end
	end

	// stage 5: planar energy against the limit
	logic v_s5;
	logic [SQ_W-1:0] rad_s5;
	side_t side_s5;
	logic [SQ_W-1:0] ssum;

	assign ssum = SQ_W'(fsq_s4) + SQ_W'(lsq_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5 <= ssum;
			side_s5.pose <= pose_s4;
			side_s5.over <= (ssum > SQ_W'(limsq_s4));
			side_s5.f_neg <= fneg_s4;
			side_s5.l_neg <= lneg_s4;
			side_s5.f_mag <= fmag_s4;
			side_s5.l_mag <= lmag_s4;
			side_s5.turn <= turn_s4;
		end
	end

	// integer square root of the planar energy
	logic v_rt;
	logic [RT_W-1:0] root_rt;
	side_t side_rt;

	bvcs_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s5),
		.in_rad(rad_s5),
		.in_side(side_s5),
		.out_valid(v_rt),
		.out_root(root_rt),
		.out_side(side_rt)
	);

	// stage 6: magnitudes times the planar limit
	logic v_s6;
	logic [NUM_W-1:0] numf_s6;
	logic [NUM_W-1:0] numl_s6;
	logic [RT_W-1:0] den_s6;
	side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_rt;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numf_s6 <= NUM_W'(side_rt.f_mag) * NUM_W'(plim_q);
			numl_s6 <= NUM_W'(side_rt.l_mag) * NUM_W'(plim_q);
			den_s6 <= root_rt;
			side_s6 <= side_rt;
		end
	end

	// scale by limit over root, truncating
	logic v_dv;
	logic [QT_W-1:0] qf_dv;
	logic [QT_W-1:0] ql_dv;
	side_t side_dv;

	bvcs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s6),
		.in_num_f(numf_s6),
		.in_num_l(numl_s6),
		.in_den(den_s6),
		.in_side(side_s6),
		.out_valid(v_dv),
		.out_q_f(qf_dv),
		.out_q_l(ql_dv),
		.out_side(side_dv)
	);

	// stage 7: output register, signs restored, no-pose zeroing
	logic signed [CMD_W-1:0] fwd_s7;
	logic signed [CMD_W-1:0] left_s7;
	logic signed [CMD_W-1:0] turn_s7;
	logic pose_s7;
	logic [CMD_W-1:0] fsel;
	logic [CMD_W-1:0] lsel;

	always_comb begin
		fsel = side_dv.over ? qf_dv : side_dv.f_mag[CMD_W-1:0];
		lsel = side_dv.over ? ql_dv : side_dv.l_mag[CMD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_dv.pose) begin
				fwd_s7 <= side_dv.f_neg ? -fsel : fsel;
				left_s7 <= side_dv.l_neg ? -lsel : lsel;
				turn_s7 <= side_dv.turn;
			end else begin
				fwd_s7 <= '0;
				left_s7 <= '0;
				turn_s7 <= '0;
			end
			pose_s7 <= side_dv.pose;
		end
	end

	assign out_valid = v_s7;
	assign forward_cmd = fwd_s7;
	assign left_cmd = left_s7;
	assign turn_cmd = turn_s7;
	assign cmd_valid = pose_s7;

endmodule
